@@ rtl/core/rrcd_pkg.sv @@
// Package for the round-robin cooldown transmit picker.
// Holds the sizes, codes and payload types used by every file of the block.
// Depends on nothing.
`default_nettype none

package rrcd_pkg;

  localparam int unsigned MAX_DEVICES  = 16;
  localparam int unsigned WINDOW_SLOTS = 16;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int unsigned DEV_W        = 4;
  localparam int unsigned CNT_W        = $clog2(MAX_DEVICES + 1);

  localparam logic [31:0] NEAR_WRAP   = 32'd4000000000;
  localparam logic [31:0] WRAP_OFFSET = 32'd1000000000;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BLINK_PERIOD   = 2'd0;
  localparam cfg_idx_t CFG_RANGE_DURATION = 2'd1;
  localparam cfg_idx_t CFG_POLL_PERIOD    = 2'd2;
  localparam cfg_idx_t CFG_ACTIVE_DEVICES = 2'd3;

  localparam logic OP_SELECT = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  typedef logic [2:0] outcome_t;
  localparam outcome_t OUT_NONE     = 3'd0;
  localparam outcome_t OUT_BLINK    = 3'd1;
  localparam outcome_t OUT_SELECTED = 3'd2;
  localparam outcome_t OUT_ADDED    = 3'd3;
  localparam outcome_t OUT_FULL     = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_ticks;
    logic [15:0] timeout_mask;
    logic [3:0]  window_device;
    logic [31:0] window_start;
    logic [31:0] window_length;
  } req_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [3:0] chosen_device;
  } res_t;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [31:0]      start;
    logic [31:0]      length;
  } slot_t;

  typedef struct packed {
    logic expired;
    logic covered;
  } eval_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } free_t;

endpackage

`default_nettype wire

@@ rtl/core/rrcd_slot_store.sv @@
// Window slot table: a memory of cooldown windows with a registered read port.
// Keeps the per-slot valid flags and finds the lowest free slot.
// Depends on rrcd_pkg.
`default_nettype none

module rrcd_slot_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [rrcd_pkg::SLOT_W-1:0]   wr_idx_i,
  input  rrcd_pkg::slot_t               wr_slot_i,
  input  logic [rrcd_pkg::SLOT_W-1:0]   rd_idx_i,
  output rrcd_pkg::slot_t               rd_slot_o,
  input  logic                          clr_en_i,
  input  logic [rrcd_pkg::SLOT_W-1:0]   clr_idx_i,
  output logic [rrcd_pkg::WINDOW_SLOTS-1:0] valid_o,
  output rrcd_pkg::free_t               free_o
);
  import rrcd_pkg::*;

  slot_t                   mem [WINDOW_SLOTS];
  slot_t                   rd_q;
  logic [WINDOW_SLOTS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_slot_i;
    end
    rd_q <= mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (clr_en_i) begin
        valid_q[clr_idx_i] <= 1'b0;
      end
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  // The lowest free slot wins, as the table is filled from the bottom.
  always_comb begin
    free_o = '0;
    for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_o.found = 1'b1;
        free_o.idx   = SLOT_W'(i);
      end
    end
  end

  assign rd_slot_o = rd_q;
  assign valid_o   = valid_q;

endmodule

`default_nettype wire

@@ rtl/core/rrcd_window_eval.sv @@
// Shared window compare unit, used once per slot during the table scan.
// Registers the offset window bounds, then tests expiry and cover.
// Depends on rrcd_pkg.
`default_nettype none

module rrcd_window_eval (
  input  logic            clk_i,
  input  logic            load_i,
  input  rrcd_pkg::slot_t slot_i,
  input  logic [31:0]     off_i,
  input  logic [31:0]     nowo_i,
  input  logic [31:0]     t2o_i,
  output rrcd_pkg::eval_t eval_o
);
  import rrcd_pkg::*;

  logic [31:0] lo_q;
  logic [31:0] hi_q;

  // All sums wrap at 32 bits.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lo_q <= slot_i.start + off_i;
      hi_q <= slot_i.start + slot_i.length + off_i;
    end
  end

  always_comb begin
    eval_o.expired = nowo_i > hi_q;
    eval_o.covered = ((nowo_i > lo_q) && (nowo_i < hi_q)) ||
                     ((t2o_i > lo_q) && (t2o_i < hi_q));
  end

endmodule

`default_nettype wire

@@ rtl/core/round_robin_cooldown_tx_picker.sv @@
// Round-robin transmit picker with per-device cooldown windows.
// Top level: sequencer, configuration registers and output register.
// Depends on rrcd_pkg, rrcd_slot_store and rrcd_window_eval.
//
// Usage: requests arrive on the in channel (valid/ready) as one req_t
// transfer; each produces exactly one res_t transfer on the out channel.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// in a single cycle, and should only be written while the block is idle.
// An add request goes from its transfer through the add state to the
// output state. A select request goes through the set-up states PREP and
// CHK, then the slot scan (one slot a cycle through the table read port
// and the shared window compare unit), then, when it searches for a
// device, the round-robin search (one device a cycle), and last the
// output state, which loads the output register.
// The block takes one request at a time; in_ready_o is high only while it
// is idle. A result waiting in the output register does not stop the next
// request from being taken, but if the receiver stalls, the following
// result is held inside the block until the output register is free.
// Reset clears the window table's valid flags, the last blink time and
// last pick, and restores the configuration registers to their defaults.
`default_nettype none

module round_robin_cooldown_tx_picker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  rrcd_pkg::cfg_idx_t cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rrcd_pkg::req_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rrcd_pkg::res_t     out_data_o
);
  import rrcd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_CHK    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_SEARCH = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // Control state.
  logic [2:0]             state_q, state_d;
  logic [31:0]            blink_period_q, blink_period_d;
  logic [31:0]            range_dur_q, range_dur_d;
  logic [31:0]            poll_period_q, poll_period_d;
  logic [CNT_W-1:0]       active_q, active_d;
  logic [31:0]            last_blink_q, last_blink_d;
  logic [DEV_W-1:0]       last_pick_q, last_pick_d;
  logic                   out_valid_q, out_valid_d;
  logic [SLOT_W:0]        issue_q, issue_d;
  logic                   p1_vld_q, p1_vld_d;
  logic                   p2_vld_q, p2_vld_d;
  logic [MAX_DEVICES-1:0] marked_q, marked_d;

  // Payload state.
  req_t                   req_q, req_d;
  logic [31:0]            off_q, off_d;
  logic [31:0]            nowo_q, nowo_d;
  logic [31:0]            limit_q, limit_d;
  logic [31:0]            t2o_q, t2o_d;
  logic                   blink_hit_q, blink_hit_d;
  logic                   skip_q, skip_d;
  logic [SLOT_W-1:0]      p1_idx_q, p1_idx_d;
  logic [SLOT_W-1:0]      p2_idx_q, p2_idx_d;
  logic [DEV_W-1:0]       p2_dev_q, p2_dev_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       k_q, k_d;
  res_t                   res_q, res_d;
  res_t                   out_data_q, out_data_d;

  // Table and compare unit connections.
  logic                    wr_en;
  slot_t                   wr_slot;
  slot_t                   rd_slot;
  logic                    clr_en;
  logic [WINDOW_SLOTS-1:0] slot_valid;
  free_t                   free;
  eval_t                   eval;

  logic [CNT_W-1:0]        n_act;
  logic [DEV_W-1:0]        idx_dev;
  logic                    dev_free;
  logic [31:0]             prep_off;
  logic [31:0]             chk_t2o;

  rrcd_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (free.idx),
    .wr_slot_i (wr_slot),
    .rd_idx_i  (issue_q[SLOT_W-1:0]),
    .rd_slot_o (rd_slot),
    .clr_en_i  (clr_en),
    .clr_idx_i (p2_idx_q),
    .valid_o   (slot_valid),
    .free_o    (free)
  );

  rrcd_window_eval u_eval (
    .clk_i  (clk_i),
    .load_i (p1_vld_q),
    .slot_i (rd_slot),
    .off_i  (off_q),
    .nowo_i (nowo_q),
    .t2o_i  (t2o_q),
    .eval_o (eval)
  );

  // A zero device count behaves as one, and counts above the device limit are
  // clipped to it.
  always_comb begin
    if (active_q == '0) begin
      n_act = CNT_W'(1);
    end else if (active_q > CNT_W'(MAX_DEVICES)) begin
      n_act = CNT_W'(MAX_DEVICES);
    end else begin
      n_act = active_q;
    end
  end

  assign idx_dev    = idx_q[DEV_W-1:0];
  assign dev_free   = !marked_q[idx_dev] && !req_q.timeout_mask[idx_dev];
  assign prep_off   = (req_q.now_ticks > NEAR_WRAP) ? WRAP_OFFSET : 32'd0;
  assign chk_t2o    = nowo_q + range_dur_q;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    blink_period_d = blink_period_q;
    range_dur_d    = range_dur_q;
    poll_period_d  = poll_period_q;
    active_d       = active_q;
    last_blink_d   = last_blink_q;
    last_pick_d    = last_pick_q;
    out_valid_d    = out_valid_q;
    issue_d        = issue_q;
    marked_d       = marked_q;
    req_d          = req_q;
    off_d          = off_q;
    nowo_d         = nowo_q;
    limit_d        = limit_q;
    t2o_d          = t2o_q;
    blink_hit_d    = blink_hit_q;
    skip_d         = skip_q;
    idx_d          = idx_q;
    k_d            = k_q;
    res_d          = res_q;
    out_data_d     = out_data_q;
    wr_en          = 1'b0;
    wr_slot        = '0;
    clr_en         = 1'b0;

    // The scan pipeline: address issue, then table data, then compare.
    p1_vld_d = (state_q == ST_SCAN) && (issue_q < (SLOT_W + 1)'(WINDOW_SLOTS));
    p1_idx_d = issue_q[SLOT_W-1:0];
    p2_vld_d = p1_vld_q;
    p2_idx_d = p1_idx_q;
    p2_dev_d = rd_slot.device;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLINK_PERIOD:   blink_period_d = cfg_data_i;
        CFG_RANGE_DURATION: range_dur_d    = cfg_data_i;
        CFG_POLL_PERIOD:    poll_period_d  = cfg_data_i;
        CFG_ACTIVE_DEVICES: active_d       = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = (in_data_i.operation == OP_ADD) ? ST_ADD : ST_PREP;
        end
      end
      ST_PREP: begin
        off_d   = prep_off;
        nowo_d  = req_q.now_ticks + prep_off;
        limit_d = last_blink_q + blink_period_q + prep_off;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        t2o_d       = chk_t2o;
        blink_hit_d = nowo_q > limit_q;
        skip_d      = chk_t2o > limit_q;
        issue_d     = '0;
        marked_d    = '0;
        idx_d       = CNT_W'(last_pick_q) + CNT_W'(1);
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_q < (SLOT_W + 1)'(WINDOW_SLOTS)) begin
          issue_d = issue_q + (SLOT_W + 1)'(1);
        end
        // The start index is brought below the device count by repeated
        // subtraction while the scan runs; the scan is long enough for it.
        if (idx_q >= n_act) begin
          idx_d = idx_q - n_act;
        end
        if (p2_vld_q && slot_valid[p2_idx_q]) begin
          if (eval.expired) begin
            clr_en = 1'b1;
          end else if ((CNT_W'(p2_dev_q) < n_act) && eval.covered) begin
            marked_d[p2_dev_q] = 1'b1;
          end
        end
        if ((issue_q == (SLOT_W + 1)'(WINDOW_SLOTS)) && !p1_vld_q && !p2_vld_q) begin
          res_d = '0;
          k_d   = '0;
          if (blink_hit_q) begin
            last_blink_d  = req_q.now_ticks;
            res_d.outcome = OUT_BLINK;
            state_d       = ST_OUT;
          end else if (skip_q) begin
            res_d.outcome = OUT_NONE;
            state_d       = ST_OUT;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (dev_free) begin
          last_pick_d          = idx_dev;
          // With the table full the pick still stands, without a window.
          wr_en                = free.found;
          wr_slot.device       = idx_dev;
          wr_slot.start        = req_q.now_ticks;
          wr_slot.length       = poll_period_q;
          res_d.outcome        = OUT_SELECTED;
          res_d.chosen_device  = idx_dev;
          state_d              = ST_OUT;
        end else if (k_q == n_act - CNT_W'(1)) begin
          res_d.outcome = OUT_NONE;
          state_d       = ST_OUT;
        end else begin
          k_d   = k_q + CNT_W'(1);
          idx_d = (idx_q + CNT_W'(1) == n_act) ? '0 : idx_q + CNT_W'(1);
        end
      end
      ST_ADD: begin
        wr_en          = free.found;
        wr_slot.device = req_q.window_device;
        wr_slot.start  = req_q.window_start;
        wr_slot.length = req_q.window_length;
        res_d          = '0;
        res_d.outcome  = free.found ? OUT_ADDED : OUT_FULL;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      blink_period_q <= 32'd1000;
      range_dur_q    <= 32'd10;
      poll_period_q  <= 32'd20;
      active_q       <= CNT_W'(1);
      last_blink_q   <= '0;
      last_pick_q    <= '0;
      out_valid_q    <= 1'b0;
      issue_q        <= '0;
      p1_vld_q       <= 1'b0;
      p2_vld_q       <= 1'b0;
      marked_q       <= '0;
    end else begin
      state_q        <= state_d;
      blink_period_q <= blink_period_d;
      range_dur_q    <= range_dur_d;
      poll_period_q  <= poll_period_d;
      active_q       <= active_d;
      last_blink_q   <= last_blink_d;
      last_pick_q    <= last_pick_d;
      out_valid_q    <= out_valid_d;
      issue_q        <= issue_d;
      p1_vld_q       <= p1_vld_d;
      p2_vld_q       <= p2_vld_d;
      marked_q       <= marked_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    off_q       <= off_d;
    nowo_q      <= nowo_d;
    limit_q     <= limit_d;
    t2o_q       <= t2o_d;
    blink_hit_q <= blink_hit_d;
    skip_q      <= skip_d;
    p1_idx_q    <= p1_idx_d;
    p2_idx_q    <= p2_idx_d;
    p2_dev_q    <= p2_dev_d;
    idx_q       <= idx_d;
    k_q         <= k_d;
    res_q       <= res_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/core/rrcd_checker.sv @@
// Port-level checker for the round-robin cooldown transmit picker.
// Bound to the top level below; depends on rrcd_pkg.
`default_nettype none

module rrcd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rrcd_pkg::res_t out_data_o
);
  import rrcd_pkg::*;

  // A stalled result must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // Only defined outcome codes are ever delivered.
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.outcome <= OUT_FULL))
    else $error("undefined outcome code");

  // The device field is zero unless a device was selected.
  a_device_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome != OUT_SELECTED)
      |-> (out_data_o.chosen_device == '0))
    else $error("device reported without a selection");

  // Once a request is taken the block is busy in the next cycle.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready straight after a request transfer");

endmodule

bind round_robin_cooldown_tx_picker rrcd_checker u_rrcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
